// File: rtl/rlt_pkg.sv
// Shared types and constants of the run queue latency tracker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rlt_pkg;

	// Event command codes.
	localparam logic [1:0] CMD_SWITCH  = 2'd0;
	localparam logic [1:0] CMD_WAKEUP  = 2'd1;
	localparam logic [1:0] CMD_MIGRATE = 2'd2;

	// Mode register layout and reset value.
	localparam int         MODE_RECORD_BIT  = 0;
	localparam int         MODE_MIGRATE_BIT = 1;
	localparam logic [1:0] MODE_RESET       = 2'b11;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// A classified event as it travels from the front to the back.
	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] ev_time;
		logic [15:0] task_id;
		logic [15:0] src_pid;
		logic [15:0] src_tid;
		logic [7:0]  cpu;
		logic        is_switch;
		logic        is_wake;
		logic        is_mig;
		logic        rec;
	} item_t;

	// One row of the wakeup store.
	typedef struct packed {
		logic        valid;
		logic [63:0] wtime;
	} wake_t;

	// One row of the statistics store.
	typedef struct packed {
		logic        valid;
		logic [31:0] switches;
		logic [63:0] total;
		logic [63:0] max_lat;
		logic [31:0] migrations;
	} stat_t;

	// One result beat.
	typedef struct packed {
		logic        record_valid;
		logic [1:0]  record_kind;
		logic [63:0] record_time;
		logic [15:0] record_prev_pid;
		logic [15:0] record_prev_tid;
		logic [15:0] record_next_pid;
		logic [7:0]  record_cpu;
		logic [63:0] latency;
		logic [31:0] switches;
		logic [63:0] total;
		logic [63:0] max_lat;
		logic [31:0] migrations;
	} result_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_ADDR,
		BK_READ,
		BK_LAT,
		BK_UPD
	} back_state_t;

endpackage

`default_nettype wire

// File: rtl/rlt_front.sv
// Front end: holds the mode register, accepts input beats and classifies them.
// Depends on rlt_pkg; pushes classified items into rlt_queue.
`default_nettype none

module rlt_front
	import rlt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [63:0] event_time,
	input  wire logic [15:0] task_id,
	input  wire logic [15:0] other_pid,
	input  wire logic [15:0] other_tid,
	input  wire logic [7:0]  cpu_index,
	input  wire logic        clearing,
	input  wire logic        q_full,
	output logic             q_push,
	output item_t            q_item
);

	logic [1:0] mode_q;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// Input beats are held off during the clearing pass and while the queue is full.
	assign in_stall = clearing | q_full;
	assign q_push   = in_valid & ~in_stall;

	// Decode the command into what the back end has to do.
	always_comb begin
		q_item           = '0;
		q_item.kind      = cmd;
		q_item.ev_time   = event_time;
		q_item.task_id   = task_id;
		q_item.cpu       = cpu_index;
		unique case (cmd)
			CMD_SWITCH: begin
				q_item.is_switch = 1'b1;
				q_item.rec       = mode_q[MODE_RECORD_BIT];
				q_item.src_pid   = other_pid;
				q_item.src_tid   = other_pid;
			end
			CMD_WAKEUP: begin
				q_item.is_wake = 1'b1;
				q_item.rec     = mode_q[MODE_RECORD_BIT];
				q_item.src_pid = other_pid;
				q_item.src_tid = other_tid;
			end
			CMD_MIGRATE: begin
				q_item.is_mig  = mode_q[MODE_MIGRATE_BIT];
				q_item.rec     = mode_q[MODE_MIGRATE_BIT] & mode_q[MODE_RECORD_BIT];
				q_item.src_pid = task_id;
				q_item.src_tid = task_id;
			end
			default: begin
				// An unknown command changes nothing and only reports statistics.
				q_item.rec = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/rlt_queue.sv
// Short queue of classified items between the front and the back.
// Depends on rlt_pkg for the item type and the depth.
`default_nettype none

module rlt_queue
	import rlt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output item_t      head,
	output logic       empty
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// File: rtl/rlt_back.sv
// Back end: per-task wakeup and statistics stores, read-modify-write sequencer
// and the output register. Depends on rlt_pkg; takes items from rlt_queue.
`default_nettype none

module rlt_back
	import rlt_pkg::*;
#(
	parameter int TASK_SLOTS = 65536
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	output logic       clearing,
	input  wire logic  q_empty,
	input  wire item_t q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output result_t    out_res
);

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	// Reciprocal for the slot modulo; zero when every 16-bit id has its own slot.
	localparam logic [31:0] RECIP = (TASK_SLOTS >= 65536) ? 32'd0 :
		32'((64'd4294967296 + 64'(TASK_SLOTS) - 64'd1) / 64'(TASK_SLOTS));

	back_state_t       state_q;
	back_state_t       state_d;
	logic [SLOT_W-1:0] clr_cnt_q;
	logic              out_valid_q;

	item_t             work_q;
	logic [15:0]       quot_q;
	logic [SLOT_W-1:0] slot_q;
	logic [63:0]       lat_q;
	result_t           out_res_q;

	wake_t             wake_mem [TASK_SLOTS];
	stat_t             stat_mem [TASK_SLOTS];
	wake_t             wake_rd_q;
	stat_t             stat_rd_q;

	logic              clr_last;
	logic              fire;
	logic [47:0]       quot_prod;
	logic [31:0]       rem;
	logic              wake_we;
	logic [SLOT_W-1:0] wake_waddr;
	wake_t             wake_wdata;
	logic              stat_we;
	logic [SLOT_W-1:0] stat_waddr;
	stat_t             stat_wdata;
	logic              stat_upd;
	stat_t             stat_new;
	stat_t             stat_rep;
	logic [63:0]       lat_next;
	result_t           res_next;

	assign clr_last  = (clr_cnt_q == SLOT_W'(TASK_SLOTS - 1));
	assign clearing  = (state_q == BK_CLEAR);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: if (clr_last) state_d = BK_IDLE;
			BK_IDLE:  if (!q_empty) state_d = BK_ADDR;
			BK_ADDR:  state_d = BK_READ;
			BK_READ:  state_d = BK_LAT;
			BK_LAT:   state_d = BK_UPD;
			BK_UPD:   if (!out_valid_q || !out_stall) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		q_pop = (state_q == BK_IDLE) && !q_empty;
		fire  = (state_q == BK_UPD) && (!out_valid_q || !out_stall);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Slot of the task: quotient by reciprocal multiply, then the remainder.
	assign quot_prod = 48'(q_head.task_id) * 48'(RECIP);
	assign rem       = 32'(work_q.task_id) - 32'(quot_q) * 32'(TASK_SLOTS);

	// Latency of a switch against a pending wakeup; wraps modulo 2^64.
	assign lat_next = (work_q.is_switch && wake_rd_q.valid) ?
		work_q.ev_time - wake_rd_q.wtime : 64'd0;

	// New statistics row for a switch of a nonzero task or an enabled migrate.
	always_comb begin
		stat_new = stat_rd_q;
		stat_upd = 1'b0;
		if (work_q.is_switch && (work_q.task_id != 16'd0)) begin
			stat_upd = 1'b1;
			if (!stat_rd_q.valid) begin
				stat_new = '{valid: 1'b1, switches: 32'd1, total: lat_q,
					max_lat: lat_q, migrations: 32'd0};
			end else begin
				stat_new.switches = stat_rd_q.switches + 32'd1;
				stat_new.total    = stat_rd_q.total + lat_q;
				if (lat_q > stat_rd_q.max_lat) begin
					stat_new.max_lat = lat_q;
				end
			end
		end else if (work_q.is_mig) begin
			stat_upd = 1'b1;
			if (stat_rd_q.valid) begin
				stat_new.migrations = stat_rd_q.migrations + 32'd1;
			end else begin
				stat_new = '{valid: 1'b1, switches: 32'd0, total: 64'd0,
					max_lat: 64'd0, migrations: 32'd1};
			end
		end
		if (stat_upd) begin
			stat_rep = stat_new;
		end else if (stat_rd_q.valid) begin
			stat_rep = stat_rd_q;
		end else begin
			stat_rep = '0;
		end
	end

	// Store write ports: the clearing pass, or the update of the current item.
	always_comb begin
		wake_we    = 1'b0;
		wake_waddr = slot_q;
		wake_wdata = '{valid: 1'b1, wtime: work_q.ev_time};
		stat_we    = fire & stat_upd;
		stat_waddr = slot_q;
		stat_wdata = stat_new;
		if (state_q == BK_CLEAR) begin
			wake_we    = 1'b1;
			wake_waddr = clr_cnt_q;
			wake_wdata = '0;
			stat_we    = 1'b1;
			stat_waddr = clr_cnt_q;
			stat_wdata = '0;
		end else if (fire && work_q.is_wake) begin
			wake_we = 1'b1;
		end else if (fire && work_q.is_switch && wake_rd_q.valid) begin
			wake_we    = 1'b1;
			wake_wdata = '{valid: 1'b0, wtime: wake_rd_q.wtime};
		end
	end

	// Result beat; record fields read as zero when no record is emitted.
	always_comb begin
		res_next              = '0;
		res_next.latency      = lat_q;
		res_next.switches     = stat_rep.switches;
		res_next.total        = stat_rep.total;
		res_next.max_lat      = stat_rep.max_lat;
		res_next.migrations   = stat_rep.migrations;
		if (work_q.rec) begin
			res_next.record_valid    = 1'b1;
			res_next.record_kind     = work_q.kind;
			res_next.record_time     = work_q.ev_time;
			res_next.record_prev_pid = work_q.src_pid;
			res_next.record_prev_tid = work_q.src_tid;
			res_next.record_next_pid = work_q.task_id;
			res_next.record_cpu      = work_q.cpu;
		end
	end

	// Working registers of the item in flight and the output register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q <= q_head;
			quot_q <= quot_prod[47:32];
		end
		if (state_q == BK_ADDR) begin
			slot_q <= rem[SLOT_W-1:0];
		end
		if (state_q == BK_LAT) begin
			lat_q <= lat_next;
		end
		if (fire) begin
			out_res_q <= res_next;
		end
	end

	// Wakeup store.
	always_ff @(posedge clk) begin
		if (wake_we) begin
			wake_mem[wake_waddr] <= wake_wdata;
		end
		wake_rd_q <= wake_mem[slot_q];
	end

	// Statistics store.
	always_ff @(posedge clk) begin
		if (stat_we) begin
			stat_mem[stat_waddr] <= stat_wdata;
		end
		stat_rd_q <= stat_mem[slot_q];
	end

endmodule

`default_nettype wire

// File: rtl/runqueue_latency_tracker_core.sv
// Run queue latency tracker. An accepted beat passes through the queue and then the
// pop, address, read, latency and update steps of the back end, which takes one
// event at a time and holds the update step while the output is stalled.
// A two-entry queue lets the input run ahead of the back end by two beats.
// After reset the stores are cleared one slot a cycle with the input stalled;
// configuration writes are taken during that pass.
`default_nettype none

module runqueue_latency_tracker_core
	import rlt_pkg::*;
#(
	parameter int TASK_SLOTS = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [63:0] event_time,
	input  wire logic [15:0] task_id,
	input  wire logic [15:0] other_pid,
	input  wire logic [15:0] other_tid,
	input  wire logic [7:0]  cpu_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             record_valid,
	output logic [1:0]       record_kind,
	output logic [63:0]      record_time,
	output logic [15:0]      record_prev_pid,
	output logic [15:0]      record_prev_tid,
	output logic [15:0]      record_next_pid,
	output logic [7:0]       record_cpu,
	output logic [63:0]      latency,
	output logic [31:0]      stat_switches,
	output logic [63:0]      stat_total_latency,
	output logic [63:0]      stat_max_latency,
	output logic [31:0]      stat_migrations
);

	logic    clearing;
	logic    q_full;
	logic    q_push;
	item_t   q_item;
	logic    q_pop;
	logic    q_empty;
	item_t   q_head;
	result_t res;

	rlt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.event_time  (event_time),
		.task_id     (task_id),
		.other_pid   (other_pid),
		.other_tid   (other_tid),
		.cpu_index   (cpu_index),
		.clearing    (clearing),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	rlt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	rlt_back #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	// Result beat onto the output ports.
	assign record_valid       = res.record_valid;
	assign record_kind        = res.record_kind;
	assign record_time        = res.record_time;
	assign record_prev_pid    = res.record_prev_pid;
	assign record_prev_tid    = res.record_prev_tid;
	assign record_next_pid    = res.record_next_pid;
	assign record_cpu         = res.record_cpu;
	assign latency            = res.latency;
	assign stat_switches      = res.switches;
	assign stat_total_latency = res.total;
	assign stat_max_latency   = res.max_lat;
	assign stat_migrations    = res.migrations;

endmodule

`default_nettype wire

// File: rtl/rlt_checker.sv
// Port-level checks of the run queue latency tracker, bound to the top level.
// Depends on rlt_pkg for the command codes.
`default_nettype none

module rlt_checker
	import rlt_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        record_valid,
	input wire logic [1:0]  record_kind,
	input wire logic [63:0] record_time,
	input wire logic [15:0] record_prev_pid,
	input wire logic [15:0] record_prev_tid,
	input wire logic [15:0] record_next_pid,
	input wire logic [7:0]  record_cpu,
	input wire logic [63:0] latency
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its latency.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(latency))
		else $error("result latency changed while stalled");

	// Without a record the record fields are zero.
	a_rec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !record_valid |-> record_kind == 2'd0 && record_time == 64'd0 &&
		record_prev_pid == 16'd0 && record_prev_tid == 16'd0 &&
		record_next_pid == 16'd0 && record_cpu == 8'd0)
		else $error("record fields set without a record");

	// A migrate record names its own task and measures no latency.
	a_mig_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_valid && record_kind == CMD_MIGRATE |->
		latency == 64'd0 && record_prev_pid == record_next_pid &&
		record_prev_tid == record_next_pid)
		else $error("malformed migrate record");

	// A switch record carries the previous task in both id fields.
	a_sw_rec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_valid && record_kind == CMD_SWITCH |->
		record_prev_pid == record_prev_tid)
		else $error("malformed switch record");

endmodule

bind runqueue_latency_tracker_core rlt_checker u_rlt_checker (.*);

`default_nettype wire
